// ----- sv/nirp_pkg.sv -----
// nirp_pkg: shared types, constants and window function for the nec ir pulse decoder
`default_nettype none
package nirp_pkg;

    localparam int TICK_W      = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int FRAME_LEN   = 32;
    localparam int POS_W       = $clog2(FRAME_LEN);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] START_TICKS_RST  = 16'd13500;
    localparam logic [CFG_W-1:0] REPEAT_TICKS_RST = 16'd11250;
    localparam logic [CFG_W-1:0] ZERO_TICKS_RST   = 16'd1120;
    localparam logic [CFG_W-1:0] ONE_TICKS_RST    = 16'd2250;
    localparam logic [CFG_W-1:0] TOL_TICKS_RST    = 16'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START  = 3'd0,
        REG_REPEAT = 3'd1,
        REG_ZERO   = 3'd2,
        REG_ONE    = 3'd3,
        REG_TOL    = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HEAD = 2'd1,
        PH_BITS = 2'd2
    } phase_t;

    // header interpretation of an interval, start wins over repeat
    typedef enum logic [1:0] {
        HC_NONE   = 2'd0,
        HC_START  = 2'd1,
        HC_REPEAT = 2'd2
    } head_class_t;

    // bit interpretation of an interval, zero wins over one
    typedef enum logic [1:0] {
        BC_NONE = 2'd0,
        BC_ZERO = 2'd1,
        BC_ONE  = 2'd2
    } bit_class_t;

    typedef struct packed {
        head_class_t head;
        bit_class_t  bitc;
    } qentry_t;

    typedef struct packed {
        logic    push;
        qentry_t entry;
    } q_push_t;

    typedef struct packed {
        logic    valid;
        qentry_t entry;
    } q_head_t;

    // n - tol < t < n + tol without wrapping, done as t + tol > n and t < n + tol
    function automatic logic in_window(
        input logic [TICK_W-1:0] t,
        input logic [CFG_W-1:0]  nominal,
        input logic [CFG_W-1:0]  tol
    );
        logic [TICK_W:0] t_plus;
        logic [CFG_W:0]  n_plus;
        t_plus = {1'b0, t} + {1'b0, tol};
        n_plus = {1'b0, nominal} + {1'b0, tol};
        return (t_plus > {1'b0, nominal}) && ({1'b0, t} < n_plus);
    endfunction

endpackage
`default_nettype wire

// ----- sv/nirp_if.sv -----
// nirp_if: edge beat and result beat channel interfaces
`default_nettype none
interface nirp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] edge_interval;

    modport source (output valid, output edge_interval, input ready);
    modport sink   (input valid, input edge_interval, output ready);
endinterface

interface nirp_out_if;
    logic       valid;
    logic       ready;
    logic       frame_done;
    logic       repeat_seen;
    logic       check_failed;
    logic [7:0] address_byte;
    logic [7:0] command_byte;
    logic [1:0] phase;

    modport source (output valid, output frame_done, output repeat_seen,
                    output check_failed, output address_byte, output command_byte,
                    output phase, input ready);
    modport sink   (input valid, input frame_done, input repeat_seen,
                    input check_failed, input address_byte, input command_byte,
                    input phase, output ready);
endinterface
`default_nettype wire

// ----- sv/nirp_front.sv -----
// nirp_front: timing registers and interval classification of incoming edge beats
`default_nettype none
module nirp_front #(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [nirp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [nirp_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                            in_valid,
    input  wire logic [nirp_pkg::TICK_W-1:0]     in_interval,
    output logic                                 in_ready,
    input  wire logic                            q_full,
    output nirp_pkg::q_push_t                    q_push
);

    localparam int MASK_W = (COUNTER_WIDTH < nirp_pkg::TICK_W) ? COUNTER_WIDTH
                                                               : nirp_pkg::TICK_W;
    localparam logic [nirp_pkg::TICK_W-1:0] TICK_MASK =
        nirp_pkg::TICK_W'(((nirp_pkg::TICK_W+1)'(1) << MASK_W) - (nirp_pkg::TICK_W+1)'(1));

    logic [nirp_pkg::CFG_W-1:0] start_reg, repeat_reg, zero_reg, one_reg, tol_reg;
    logic [nirp_pkg::TICK_W-1:0] t_masked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= nirp_pkg::START_TICKS_RST;
            repeat_reg <= nirp_pkg::REPEAT_TICKS_RST;
            zero_reg   <= nirp_pkg::ZERO_TICKS_RST;
            one_reg    <= nirp_pkg::ONE_TICKS_RST;
            tol_reg    <= nirp_pkg::TOL_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nirp_pkg::REG_START:  start_reg  <= cfg_wdata;
                nirp_pkg::REG_REPEAT: repeat_reg <= cfg_wdata;
                nirp_pkg::REG_ZERO:   zero_reg   <= cfg_wdata;
                nirp_pkg::REG_ONE:    one_reg    <= cfg_wdata;
                nirp_pkg::REG_TOL:    tol_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign t_masked = in_interval & TICK_MASK;
    assign in_ready = !q_full;

    always_comb
    begin
        q_push.push = in_valid && !q_full;
        priority if (nirp_pkg::in_window(t_masked, start_reg, tol_reg))
            q_push.entry.head = nirp_pkg::HC_START;
        else if (nirp_pkg::in_window(t_masked, repeat_reg, tol_reg))
            q_push.entry.head = nirp_pkg::HC_REPEAT;
        else
            q_push.entry.head = nirp_pkg::HC_NONE;
        priority if (nirp_pkg::in_window(t_masked, zero_reg, tol_reg))
            q_push.entry.bitc = nirp_pkg::BC_ZERO;
        else if (nirp_pkg::in_window(t_masked, one_reg, tol_reg))
            q_push.entry.bitc = nirp_pkg::BC_ONE;
        else
            q_push.entry.bitc = nirp_pkg::BC_NONE;
    end

endmodule
`default_nettype wire

// ----- sv/nirp_queue.sv -----
// nirp_queue: short fifo of classified edges between front and back
`default_nettype none
module nirp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire nirp_pkg::q_push_t q_push,
    output logic                   q_full,
    output nirp_pkg::q_head_t      q_head,
    input  wire logic              q_pop
);

    localparam int PTR_W = $clog2(nirp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(nirp_pkg::QUEUE_DEPTH + 1);

    nirp_pkg::qentry_t slot_reg [nirp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign q_full       = (count_reg == CNT_W'(nirp_pkg::QUEUE_DEPTH));
    assign q_head.valid = (count_reg != '0);
    assign q_head.entry = slot_reg[rd_ptr_reg];
    assign do_pop       = q_pop && q_head.valid;

    always_comb
    begin
        count_next = count_reg;
        if (q_push.push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !q_push.push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (q_push.push)
            slot_reg[wr_ptr_reg] <= q_push.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_push.push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(nirp_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(nirp_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/nirp_back.sv -----
// nirp_back: frame state machine and registered result beat
`default_nettype none
module nirp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire nirp_pkg::q_head_t q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_frame_done,
    output logic                   out_repeat_seen,
    output logic                   out_check_failed,
    output logic [7:0]             out_address,
    output logic [7:0]             out_command,
    output logic [1:0]             out_phase
);

    nirp_pkg::phase_t               phase_reg, phase_next;
    logic [nirp_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [nirp_pkg::FRAME_LEN-1:0] bits_reg, bits_next;
    logic [7:0]                     addr_reg, addr_next, cmd_reg, cmd_next;
    logic                           done, rep, fail;
    logic                           out_valid_reg;
    logic                           done_reg, rep_reg, fail_reg;
    logic [7:0]                     oaddr_reg, ocmd_reg;
    logic [1:0]                     ophase_reg;

    // take a queued edge when the result register is empty or being drained
    assign q_pop = q_head.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        bits_next  = bits_reg;
        addr_next  = addr_reg;
        cmd_next   = cmd_reg;
        done       = 1'b0;
        rep        = 1'b0;
        fail       = 1'b0;
        unique case (phase_reg)
            nirp_pkg::PH_HEAD:
            begin
                priority if (q_head.entry.head == nirp_pkg::HC_START)
                    phase_next = nirp_pkg::PH_BITS;
                else if (q_head.entry.head == nirp_pkg::HC_REPEAT)
                begin
                    rep        = 1'b1;
                    phase_next = nirp_pkg::PH_IDLE;
                end
            end
            nirp_pkg::PH_BITS:
            begin
                if (q_head.entry.bitc == nirp_pkg::BC_NONE)
                begin
                    pos_next   = '0;
                    phase_next = nirp_pkg::PH_HEAD;
                end
                else
                begin
                    bits_next[pos_reg] = (q_head.entry.bitc == nirp_pkg::BC_ONE);
                    if (pos_reg == nirp_pkg::POS_W'(nirp_pkg::FRAME_LEN - 1))
                    begin
                        pos_next   = '0;
                        phase_next = nirp_pkg::PH_IDLE;
                        if (bits_next[7:0] == ~bits_next[15:8] &&
                            bits_next[23:16] == ~bits_next[31:24])
                        begin
                            addr_next = bits_next[7:0];
                            cmd_next  = bits_next[23:16];
                            done      = 1'b1;
                        end
                        else
                            fail = 1'b1;
                    end
                    else
                        pos_next = pos_reg + nirp_pkg::POS_W'(1);
                end
            end
            default:
                phase_next = nirp_pkg::PH_HEAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= nirp_pkg::PH_IDLE;
            pos_reg       <= '0;
            bits_reg      <= '0;
            addr_reg      <= '0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                bits_reg  <= bits_next;
                addr_reg  <= addr_next;
                cmd_reg   <= cmd_next;
            end
            if (q_pop)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            done_reg   <= done;
            rep_reg    <= rep;
            fail_reg   <= fail;
            oaddr_reg  <= addr_next;
            ocmd_reg   <= cmd_next;
            ophase_reg <= phase_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_frame_done   = done_reg;
    assign out_repeat_seen  = rep_reg;
    assign out_check_failed = fail_reg;
    assign out_address      = oaddr_reg;
    assign out_command      = ocmd_reg;
    assign out_phase        = ophase_reg;

endmodule
`default_nettype wire

// ----- sv/nec_ir_pulse_decoder.sv -----
// nec_ir_pulse_decoder: top level of the nec infrared frame decoder
// an accepted edge beat is queued, then its result is registered before the result beat is valid
// throughput: one edge beat per cycle while result beats are taken, set by the back end state update
// the two-entry queue absorbs a stall on the result side while edges keep arriving
// reset: asynchronous active low; timing registers return to nominal nec values,
// decoder goes idle with bit count, frame word and held address/command cleared
`default_nettype none
module nec_ir_pulse_decoder #(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    nirp_in_if.sink                              in_ch,
    nirp_out_if.source                           out_ch,
    input  wire logic                            cfg_we,
    input  wire logic [nirp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [nirp_pkg::CFG_W-1:0]      cfg_wdata
);

    // classified edge moving from front to queue
    nirp_pkg::q_push_t q_push;
    // oldest classified edge waiting for the back end
    nirp_pkg::q_head_t q_head;
    logic              q_full;
    logic              q_pop;

    // front: register file plus window compares, classifies without decoder state
    nirp_front #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_ch.valid),
        .in_interval (in_ch.edge_interval),
        .in_ready    (in_ch.ready),
        .q_full      (q_full),
        .q_push      (q_push)
    );

    // decoupling queue, push and pop may happen in the same cycle
    nirp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .q_head (q_head),
        .q_pop  (q_pop)
    );

    // back: phase machine, frame shift-in, complement checks, result register
    nirp_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .out_frame_done   (out_ch.frame_done),
        .out_repeat_seen  (out_ch.repeat_seen),
        .out_check_failed (out_ch.check_failed),
        .out_address      (out_ch.address_byte),
        .out_command      (out_ch.command_byte),
        .out_phase        (out_ch.phase)
    );

endmodule
`default_nettype wire

// ----- sv/nirp_checker.sv -----
// nirp_checker: port-level assertions for the decoder, bound to the top level
`default_nettype none
module nirp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       frame_done,
    input wire logic       repeat_seen,
    input wire logic       check_failed,
    input wire logic [1:0] phase
);

    // at most one event flag per result beat
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({frame_done, repeat_seen, check_failed}))
        else $error("more than one event flag in a result beat");

    // every completed frame, repeat or failed check leaves the decoder idle
    a_event_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_done || repeat_seen || check_failed) |->
            (phase == nirp_pkg::PH_IDLE))
        else $error("event reported without returning to idle");

    // the unused phase code never shows up
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (phase <= nirp_pkg::PH_BITS))
        else $error("illegal phase code on result beat");

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

endmodule

bind nec_ir_pulse_decoder nirp_checker u_nirp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .frame_done   (out_ch.frame_done),
    .repeat_seen  (out_ch.repeat_seen),
    .check_failed (out_ch.check_failed),
    .phase        (out_ch.phase)
);
`default_nettype wire
